// ----- rtl/core/lmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmpf_pkg - shared types and constants of the 3x3 local maximum peak finder
// Register indexes, field widths, default sizes and the peak record type.
// ----------------------------------------------------------------------------
package lmpf_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 32;

  // fixed port widths
  localparam int IN_W      = 32;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  // frame size after reset, before clamping to the maximum
  localparam int RESET_LEN = 4096;

  // peak queue between front and back (power of two)
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } peak_t;

  typedef struct packed {
    logic  valid;
    peak_t peak;
  } peak_push_t;

endpackage

// ----- rtl/core/lmpf_front.sv -----
// ----------------------------------------------------------------------------
// lmpf_front - sample intake, line buffers, 3x3 window and peak test
// Two-stage pipe: stage 0 reads the line buffers, stage 1 writes them back,
// shifts the window and pushes detected peaks into the queue.
// ----------------------------------------------------------------------------
module lmpf_front #(
  parameter int MAX_WIDTH   = lmpf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = lmpf_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = lmpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [lmpf_pkg::IN_W-1:0]         in_sample,
  input  logic                              cfg_we,
  input  logic [lmpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lmpf_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [lmpf_pkg::QCOUNT_W-1:0]     q_count,
  output lmpf_pkg::peak_push_t              push
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int LW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int QSUM_W = lmpf_pkg::QCOUNT_W + 1;
  localparam int RST_W  = (lmpf_pkg::RESET_LEN > MAX_WIDTH) ? MAX_WIDTH : lmpf_pkg::RESET_LEN;
  localparam int RST_H  = (lmpf_pkg::RESET_LEN > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : lmpf_pkg::RESET_LEN;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  // frame geometry and position of the next sample
  logic [LW-1:0] row_len_r, row_len_nxt;
  logic [HW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [LW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  // stage 1
  logic          s1_valid_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  smp_t          s1_sample_r;
  smp_t          upper_rd_r, middle_rd_r;
  logic          fwd_r;
  smp_t          fwd_top_r, fwd_mid_r;
  smp_t          win_r [6];

  smp_t          upper_mem  [MAX_WIDTH];
  smp_t          middle_mem [MAX_WIDTH];

  logic          accept;
  smp_t          smp_in;
  smp_t          top1, mid1, centre;
  logic          is_peak;
  logic [CW-1:0] x_m1;
  logic [RW-1:0] y_m1;

  assign in_ready = (QSUM_W'(q_count) + QSUM_W'(s1_valid_r)) < QSUM_W'(lmpf_pkg::QDEPTH);
  assign accept   = in_valid && in_ready;
  assign smp_in   = in_sample[SAMPLE_BITS-1:0];

  // ---- position counters and configuration ----
  always_comb begin
    row_len_nxt = row_len_r;
    row_cnt_nxt = row_cnt_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    col_inc     = LW'(col_r) + LW'(1);
    row_inc     = HW'(row_r) + HW'(1);
    if (accept) begin
      if (col_inc >= row_len_r) begin
        col_nxt = '0;
        row_nxt = (row_inc >= row_cnt_r) ? '0 : row_inc[RW-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
    if (cfg_we) begin
      unique case (cfg_index)
        lmpf_pkg::REG_ROW_LENGTH: begin
          if (cfg_wdata == '0) row_len_nxt = LW'(1);
          else if (32'(cfg_wdata) > MAX_WIDTH) row_len_nxt = LW'(MAX_WIDTH);
          else row_len_nxt = LW'(cfg_wdata);
          col_nxt = '0;
          row_nxt = '0;
        end
        lmpf_pkg::REG_ROW_COUNT: begin
          if (cfg_wdata == '0) row_cnt_nxt = HW'(1);
          else if (32'(cfg_wdata) > MAX_HEIGHT) row_cnt_nxt = HW'(MAX_HEIGHT);
          else row_cnt_nxt = HW'(cfg_wdata);
          col_nxt = '0;
          row_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r  <= LW'(RST_W);
      row_cnt_r  <= HW'(RST_H);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_len_r  <= row_len_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
    end
  end

  // ---- stage 0 -> 1 payload; bypass when stage 1 writes the column read now ----
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_sample_r <= smp_in;
      fwd_r       <= s1_valid_r && (s1_col_r == col_r);
      fwd_top_r   <= mid1;
      fwd_mid_r   <= s1_sample_r;
    end
  end

  // line buffers: read at stage 0, written back at stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd_r  <= upper_mem[col_r];
      middle_rd_r <= middle_mem[col_r];
    end
    if (s1_valid_r) begin
      upper_mem[s1_col_r]  <= mid1;
      middle_mem[s1_col_r] <= s1_sample_r;
    end
  end

  // ---- stage 1: window and strict maximum test ----
  assign top1   = fwd_r ? fwd_top_r : upper_rd_r;
  assign mid1   = fwd_r ? fwd_mid_r : middle_rd_r;
  assign centre = win_r[4];
  assign x_m1   = s1_col_r - CW'(1);
  assign y_m1   = s1_row_r - RW'(1);

  assign is_peak = (s1_col_r >= CW'(2)) && (s1_row_r >= RW'(2)) &&
                   (centre > win_r[0]) && (centre > win_r[1]) &&
                   (centre > win_r[2]) && (centre > win_r[3]) &&
                   (centre > win_r[5]) && (centre > top1) &&
                   (centre > mid1) && (centre > s1_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top1;
      win_r[4] <= mid1;
      win_r[5] <= s1_sample_r;
    end
  end

  assign push.valid  = s1_valid_r && is_peak;
  assign push.peak.x = lmpf_pkg::COORD_W'(x_m1);
  assign push.peak.y = lmpf_pkg::COORD_W'(y_m1);

  // a reported peak never lies on the left or top border
  a_peak_inside: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (s1_col_r >= CW'(2)) && (s1_row_r >= RW'(2)))
    else $error("peak pushed on a border position");

  // bypass only arises for a column revisited on the very next transfer
  a_fwd_single_col: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_valid_r && (s1_col_r == col_r)) |-> (row_len_r == LW'(1)))
    else $error("line buffer bypass with row length above one");

endmodule

// ----- rtl/core/lmpf_queue.sv -----
// ----------------------------------------------------------------------------
// lmpf_queue - short FIFO of peak records between front and back
// Lets the front keep streaming while the back waits on the result channel.
// ----------------------------------------------------------------------------
module lmpf_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lmpf_pkg::peak_push_t          push,
  input  logic                          pop,
  output lmpf_pkg::peak_t               head,
  output logic [lmpf_pkg::QCOUNT_W-1:0] count
);

  lmpf_pkg::peak_t                 mem_r [lmpf_pkg::QDEPTH];
  logic [lmpf_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [lmpf_pkg::QCOUNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) count_nxt = count_r + lmpf_pkg::QCOUNT_W'(1);
    else if (!push.valid && pop) count_nxt = count_r - lmpf_pkg::QCOUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) wr_ptr_r <= wr_ptr_r + lmpf_pkg::QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + lmpf_pkg::QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) mem_r[wr_ptr_r] <= push.peak;
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid && !pop |-> count_r < lmpf_pkg::QCOUNT_W'(lmpf_pkg::QDEPTH))
    else $error("peak queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("peak queue popped while empty");

endmodule

// ----- rtl/core/lmpf_back.sv -----
// ----------------------------------------------------------------------------
// lmpf_back - result channel output register
// Takes the queue head whenever the output register is free or being drained.
// ----------------------------------------------------------------------------
module lmpf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lmpf_pkg::peak_t               head,
  input  logic [lmpf_pkg::QCOUNT_W-1:0] count,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lmpf_pkg::COORD_W-1:0]  out_peak_x,
  output logic [lmpf_pkg::COORD_W-1:0]  out_peak_y
);

  logic            out_valid_r;
  lmpf_pkg::peak_t out_data_r;
  logic            load;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && (count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= (count != '0);
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= head;
  end

  assign out_valid  = out_valid_r;
  assign out_peak_x = out_data_r.x;
  assign out_peak_y = out_data_r.y;

endmodule

// ----- rtl/core/local_max_3x3_peak_finder_top.sv -----
// ----------------------------------------------------------------------------
// local_max_3x3_peak_finder_top - 3x3 strict local maximum peak finder
// A peak is tested in front stage 1 with the sample below and right of it,
//   then queued and registered.  Throughput: one sample per cycle while the
//   queue has room, set by the single read and write port of each line buffer.
// Reset: counters cleared, row length and count set to 4096 (clamped to the
//   maximum); line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
//
// Structure
//   front : position counters, configuration, two line buffers (one RAM per
//           line, registered read), six-cell window and the peak compare.
//   queue : four-entry FIFO of peak coordinates.
//   back  : output register on the result channel.
//
// The front only takes a sample when the queue has room for both the item
// in its second stage and the new one, so it never has to hold a result.
// The back drains the queue independently of the input side.
//
// A write to either size register restarts the frame at column 0, row 0.
// Values of 0 act as 1, values above the maximum act as the maximum.
module local_max_3x3_peak_finder_top #(
  parameter int MAX_WIDTH   = lmpf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = lmpf_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = lmpf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample stream, raster order
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lmpf_pkg::IN_W-1:0]      in_sample,
  // peak coordinates
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lmpf_pkg::COORD_W-1:0]   out_peak_x,
  output logic [lmpf_pkg::COORD_W-1:0]   out_peak_y,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [lmpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmpf_pkg::CFG_W-1:0]     cfg_wdata
);

  lmpf_pkg::peak_push_t          push;
  lmpf_pkg::peak_t               head;
  logic [lmpf_pkg::QCOUNT_W-1:0] q_count;
  logic                          pop;

  lmpf_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .push      (push)
  );

  lmpf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  lmpf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .count      (q_count),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_peak_x (out_peak_x),
    .out_peak_y (out_peak_y)
  );

endmodule

// ----- verif/local_max_3x3_peak_finder_top_tb.sv -----
// ----------------------------------------------------------------------------
// local_max_3x3_peak_finder_top_tb - self-checking bench for the peak finder
// Streams raster frames of many shapes through the block. A software copy of
// the line buffers and window predicts every strict 3x3 maximum. Each peak
// transfer is compared against the oldest predicted peak, under varied flow
// control on both channels.
// ----------------------------------------------------------------------------

// Software copy of the peak finder: line buffers, window, position and the
// queue of peaks it has predicted but the block has not yet delivered.
class peak_predictor;
  logic signed [31:0] upper_row  [lmpf_pkg::DEF_MAX_WIDTH];
  logic signed [31:0] middle_row [lmpf_pkg::DEF_MAX_WIDTH];
  logic signed [31:0] win [6];
  int unsigned col, row, width, height;
  lmpf_pkg::peak_t expected_peaks [$];
  int unsigned sample_count, peak_count, errors;

  function new();
    foreach (upper_row[i]) begin
      upper_row[i]  = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col    = 0;
    row    = 0;
    width  = clamp_size(lmpf_pkg::RESET_LEN, lmpf_pkg::DEF_MAX_WIDTH);
    height = clamp_size(lmpf_pkg::RESET_LEN, lmpf_pkg::DEF_MAX_HEIGHT);
  endfunction

  // zero behaves as one, oversize as the maximum
  function int unsigned clamp_size(int unsigned v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function int unsigned pending();
    return expected_peaks.size();
  endfunction

  function void set_reg(logic [lmpf_pkg::CFG_IDX_W-1:0] idx,
                        logic [lmpf_pkg::CFG_W-1:0] v);
    if (idx == lmpf_pkg::REG_ROW_LENGTH)
      width = clamp_size(32'(v), lmpf_pkg::DEF_MAX_WIDTH);
    else if (idx == lmpf_pkg::REG_ROW_COUNT)
      height = clamp_size(32'(v), lmpf_pkg::DEF_MAX_HEIGHT);
    else return;
    col = 0;
    row = 0;
  endfunction

  function void note_sample(logic [31:0] raw);
    logic signed [31:0] cur, top, mid, ctr;
    lmpf_pkg::peak_t pk;
    cur = raw;
    top = upper_row[col];
    mid = middle_row[col];
    upper_row[col]  = mid;
    middle_row[col] = cur;
    sample_count++;
    if (col >= 2 && row >= 2) begin
      ctr = win[4];
      if (ctr > win[0] && ctr > win[1] && ctr > win[2] && ctr > win[3] &&
          ctr > win[5] && ctr > top && ctr > mid && ctr > cur) begin
        pk.x = 12'(col - 1);
        pk.y = 12'(row - 1);
        expected_peaks.insert(expected_peaks.size(), pk);
      end
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = cur;
    col++;
    if (col >= width) begin
      col = 0;
      row++;
      if (row >= height) row = 0;
    end
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 40) $display("%0t: %s", $time, msg);
  endfunction

  function void check_peak(logic [11:0] got_x, logic [11:0] got_y);
    lmpf_pkg::peak_t want;
    if (expected_peaks.size() == 0) begin
      flag($sformatf("unexpected peak transfer, actual x=%0d y=%0d", got_x, got_y));
      return;
    end
    want = expected_peaks.pop_front();
    peak_count++;
    if (got_x !== want.x)
      flag($sformatf("peak_x expected %0d actual %0d", want.x, got_x));
    if (got_y !== want.y)
      flag($sformatf("peak_y expected %0d actual %0d", want.y, got_y));
  endfunction
endclass

module local_max_3x3_peak_finder_top_tb;

  // flow control profiles for the two channels
  typedef enum {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;
  // flavours of sample content
  typedef enum {VAL_WIDE, VAL_NARROW, VAL_EDGE} value_mix_e;

  // indexes beyond the register list; writes there must be ignored
  localparam logic [lmpf_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
  localparam logic [lmpf_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;

  localparam int unsigned SAMPLE_TARGET = 1500;
  // peak shows once the lower-right sample has passed the pipe; allow slack
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam longint      TIME_LIMIT    = 15_000_000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [lmpf_pkg::IN_W-1:0]          in_sample = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [lmpf_pkg::COORD_W-1:0]       out_peak_x;
  logic [lmpf_pkg::COORD_W-1:0]       out_peak_y;
  logic                               cfg_we = 1'b0;
  logic [lmpf_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [lmpf_pkg::CFG_W-1:0]         cfg_wdata = '0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  peak_predictor peak_pred = new();

  local_max_3x3_peak_finder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_peak_x (out_peak_x),
    .out_peak_y (out_peak_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check every peak transfer, then pick the next ready level.
  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    if (out_valid && out_ready) peak_pred.check_peak(out_peak_x, out_peak_y);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SRC_IDLE:   begin idle_pct = 80; stall_pct = 0;  end
      PACE_SINK_STALL: begin idle_pct = 0;  stall_pct = 80; end
      PACE_BOTH:       begin idle_pct = 11; stall_pct = 11; end
      default:         begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // One sample transfer. Valid may drop during a random gap but never while
  // a sample is offered; the predictor learns the sample once it is taken.
  task automatic push_sample(input logic [lmpf_pkg::IN_W-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    peak_pred.note_sample(value);
  endtask

  // Stop offering samples until every predicted peak has been delivered.
  // The wait always includes a clock edge, so valid is not driven twice in one step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (peak_pred.pending() != 0);
  endtask

  // Idle point for register writes: a sample that makes no peak may still be
  // in the pipe after the last peak, hence the extra cycles.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lmpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lmpf_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    peak_pred.set_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [lmpf_pkg::IN_W-1:0] next_value(input value_mix_e mix);
    case (mix)
      // tiny range: lots of ties, so strictness gets exercised
      VAL_NARROW: return 32'($urandom_range(4)) - 32'd2;
      VAL_EDGE: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h8000_0001;
          default: return $urandom;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly small frames; now and then zero, one, two, the maximum or beyond.
  function automatic logic [lmpf_pkg::CFG_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8)  return '0;
    if (r < 14) return 13'($urandom_range(1, 2));
    if (r < 70) return 13'($urandom_range(3, 12));
    if (r < 85) return 13'($urandom_range(13, 40));
    if (r < 92) return 13'd4096;
    return 13'($urandom_range(4097, 8191));
  endfunction

  task automatic stream(input int unsigned n, input value_mix_e mix, input bit hold_mid);
    for (int unsigned i = 0; i < n; i++) begin
      // sender holds off mid-phase until the result side has caught up
      if (hold_mid && i == n / 2) drain();
      push_sample(next_value(mix));
    end
  endtask

  // 3x3 frame: given centre, a ring of equal neighbours, and a separately
  // given lower-right corner sample.
  task automatic push_frame3(input logic [lmpf_pkg::IN_W-1:0] centre,
                             input logic [lmpf_pkg::IN_W-1:0] ring,
                             input logic [lmpf_pkg::IN_W-1:0] corner);
    for (int i = 0; i < 9; i++)
      push_sample(i == 4 ? centre : (i == 8 ? corner : ring));
  endtask

  // One whole long, thin frame of negative noise, plus a single maximum spike
  // at (sx, sy) so that a far coordinate is certain to be reported.
  task automatic stream_spiked(input logic [lmpf_pkg::CFG_W-1:0] len,
                               input logic [lmpf_pkg::CFG_W-1:0] cnt,
                               input int unsigned sx, input int unsigned sy);
    settle();
    write_reg(lmpf_pkg::REG_ROW_LENGTH, len);
    write_reg(lmpf_pkg::REG_ROW_COUNT, cnt);
    for (int unsigned i = 0; i < len * cnt; i++)
      push_sample((peak_pred.col == sx && peak_pred.row == sy) ? 32'h7FFF_FFFF
                                                               : ($urandom | 32'h8000_0000));
  endtask

  initial begin
    int unsigned n, random_items, phases;
    value_mix_e  mix;

    random_items = 0;
    phases       = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: writes beyond the register list, then tiny 3x3 frames ---
    write_reg(IDX_SPARE_LO, 13'h1FFF);
    write_reg(IDX_SPARE_HI, 13'h0AAA);
    write_reg(lmpf_pkg::REG_ROW_LENGTH, 13'd3);
    write_reg(lmpf_pkg::REG_ROW_COUNT, 13'd3);
    // largest positive over most negative: a peak
    push_frame3(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    // centre ties with the corner: no peak
    push_frame3(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    // zero beats minus one in signed terms: a peak
    push_frame3(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);

    // --- random phases, cycling through the flow control profiles ---
    while (random_items < SAMPLE_TARGET) begin
      settle();
      set_pace(pace_e'(phases % 4));
      // an ignored index must neither resize nor restart the frame
      if ($urandom_range(99) < 15)
        write_reg($urandom_range(1) ? IDX_SPARE_HI : IDX_SPARE_LO, 13'($urandom));
      if (phases == 0 || $urandom_range(99) < 85)
        write_reg(lmpf_pkg::REG_ROW_LENGTH, pick_size());
      if (phases == 0 || $urandom_range(99) < 85)
        write_reg(lmpf_pkg::REG_ROW_COUNT, pick_size());
      mix = value_mix_e'($urandom_range(2));
      // a frame or two plus a partial one (at most 150 samples), so restarts also land mid-frame
      n = peak_pred.width * peak_pred.height * $urandom_range(1, 2) +
          $urandom_range(0, peak_pred.width);
      if (n > 150) n = $urandom_range(60, 150);
      stream(n, mix, phases % 5 == 2);
      random_items += n;
      phases++;
    end

    // --- whole long, thin frames, reaching the far column and row ---
    set_pace(PACE_BOTH);
    stream_spiked(13'd64, 13'd3, 62, 1);
    stream_spiked(13'd3, 13'd64, 1, 62);

    drain();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);

    $display("%0d samples over %0d random phases and two long, thin frames",
             peak_pred.sample_count, phases);
    $display("%0d peak transfers compared, %0d errors", peak_pred.peak_count,
             peak_pred.errors);
    if (peak_pred.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(TIME_LIMIT);
    $display("%0t: timeout, %0d peaks still expected", $time, peak_pred.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/lmpf_pkg.sv
rtl/core/lmpf_front.sv
rtl/core/lmpf_queue.sv
rtl/core/lmpf_back.sv
rtl/core/local_max_3x3_peak_finder_top.sv
verif/local_max_3x3_peak_finder_top_tb.sv
